// ===== rtl/m3inv_pkg.sv =====
package m3inv_pkg;

	// element and intermediate widths
	localparam int DW          = 32;
	localparam int FB_DEF      = 16;
	localparam int CW          = 2 * DW + 1;
	localparam int DETW        = 3 * DW + 3;
	localparam int NE          = 9;
	localparam int Q_DEPTH_DEF = 4;

	typedef logic signed [DW-1:0]   elem_t;
	typedef logic signed [2*DW-1:0] prod_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic signed [DETW-1:0] det_t;

	typedef struct packed {
		elem_t in_m00;
		elem_t in_m01;
		elem_t in_m02;
		elem_t in_m10;
		elem_t in_m11;
		elem_t in_m12;
		elem_t in_m20;
		elem_t in_m21;
		elem_t in_m22;
	} req_t;

	typedef struct packed {
		elem_t out_m00;
		elem_t out_m01;
		elem_t out_m02;
		elem_t out_m10;
		elem_t out_m11;
		elem_t out_m12;
		elem_t out_m20;
		elem_t out_m21;
		elem_t out_m22;
		elem_t determinant;
		logic  singular;
	} res_t;

	// one classified request between front and back
	typedef struct packed {
		elem_t [NE-1:0] e;
		cof_t  [NE-1:0] c;
		det_t           det;
		logic           singular;
	} entry_t;

	// adjugate entry i = e[PA_X]*e[PA_Y] - e[PB_X]*e[PB_Y], row-major
	localparam int PA_X [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int PA_Y [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int PB_X [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int PB_Y [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

// ===== rtl/matrix3_inverse_determinant.sv =====
// Path from request to result with no stall: 4 front stages, queue,
// 2 setup stages, one restoring divider stage per result bit, output register.
// Throughput: one request per cycle unless stalled; nine pipelined dividers work side by side.
// The front stalls only when the queue is full; the back only on result stall.
// Reset (arst_n, asynchronous, active low) clears all valid bits and the queue.
module matrix3_inverse_determinant #(
	parameter int FRAC_BITS = m3inv_pkg::FB_DEF,
	parameter int Q_DEPTH   = m3inv_pkg::Q_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  m3inv_pkg::req_t req,
	output logic            res_valid,
	input  logic            res_stall,
	output m3inv_pkg::res_t res
);
	import m3inv_pkg::*;

	logic   q_wr, q_rd, q_full, q_empty;
	entry_t q_wdata, q_rdata;

	assign req_stall = q_full;

	m3inv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (req_valid),
		.req    (req),
		.adv    (!q_full),
		.wr     (q_wr),
		.wdata  (q_wdata)
	);

	m3inv_queue #(.DEPTH(Q_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	m3inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (!q_empty),
		.rdata     (q_rdata),
		.rd        (q_rd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== rtl/m3inv_front.sv =====
module m3inv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	input  m3inv_pkg::req_t      req,
	input  logic                 adv,
	output logic                 wr,
	output m3inv_pkg::entry_t    wdata
);
	import m3inv_pkg::*;

	elem_t e_in [NE];
	logic  valid_s1, valid_s2, valid_s3, valid_s4;
	elem_t e_s1 [NE];
	elem_t e_s2 [NE];
	elem_t e_s3 [NE];
	elem_t e_s4 [NE];
	prod_t pa_s1 [NE];
	prod_t pb_s1 [NE];
	cof_t  c_s2 [NE];
	cof_t  c_s3 [NE];
	cof_t  c_s4 [NE];
	prod_t                ph_s3 [3];
	logic signed [2*DW+1:0] pl_s3 [3];
	det_t  det_s4;

	assign e_in[0] = req.in_m00;
	assign e_in[1] = req.in_m01;
	assign e_in[2] = req.in_m02;
	assign e_in[3] = req.in_m10;
	assign e_in[4] = req.in_m11;
	assign e_in[5] = req.in_m12;
	assign e_in[6] = req.in_m20;
	assign e_in[7] = req.in_m21;
	assign e_in[8] = req.in_m22;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// element products, then cofactors
	for (genvar i = 0; i < NE; i++) begin : g_cof
		always_ff @(posedge clk) begin
			if (adv) begin
				e_s1[i]  <= e_in[i];
				pa_s1[i] <= e_in[PA_X[i]] * e_in[PA_Y[i]];
				pb_s1[i] <= e_in[PB_X[i]] * e_in[PB_Y[i]];
				e_s2[i]  <= e_s1[i];
				c_s2[i]  <= cof_t'(pa_s1[i]) - cof_t'(pb_s1[i]);
				e_s3[i]  <= e_s2[i];
				c_s3[i]  <= c_s2[i];
				e_s4[i]  <= e_s3[i];
				c_s4[i]  <= c_s3[i];
			end
		end
	end

	// split row-0 expansion into high and low partial products
	for (genvar k = 0; k < 3; k++) begin : g_det
		always_ff @(posedge clk) begin
			if (adv) begin
				ph_s3[k] <= e_s2[k] * $signed(c_s2[3*k][CW-1:DW+1]);
				pl_s3[k] <= e_s2[k] * $signed({1'b0, c_s2[3*k][DW:0]});
			end
		end
	end

	// sum partial products into the exact determinant
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= (det_t'(ph_s3[0]) <<< (DW + 1)) + det_t'(pl_s3[0])
				+ (det_t'(ph_s3[1]) <<< (DW + 1)) + det_t'(pl_s3[1])
				+ (det_t'(ph_s3[2]) <<< (DW + 1)) + det_t'(pl_s3[2]);
		end
	end

	// classify and hand to the queue
	assign wr = valid_s4 && adv;
	always_comb begin
		for (int i = 0; i < NE; i++) begin
			wdata.e[i] = e_s4[i];
			wdata.c[i] = c_s4[i];
		end
		wdata.det      = det_s4;
		wdata.singular = (det_s4 == '0);
	end

endmodule

// ===== rtl/m3inv_queue.sv =====
module m3inv_queue #(
	parameter int DEPTH = m3inv_pkg::Q_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  m3inv_pkg::entry_t wdata,
	input  logic              rd,
	output m3inv_pkg::entry_t rdata,
	output logic              full,
	output logic              empty
);
	import m3inv_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [NW-1:0]  cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// store request
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/m3inv_back.sv =====
module m3inv_back #(
	parameter int FRAC_BITS = m3inv_pkg::FB_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  m3inv_pkg::entry_t rdata,
	output logic              rd,
	output logic              res_valid,
	input  logic              res_stall,
	output m3inv_pkg::res_t   res
);
	import m3inv_pkg::*;

	localparam int F2   = 2 * FRAC_BITS;
	localparam int NW   = CW + F2;
	localparam int CMPW = DETW + DW;
	localparam int RW   = DETW + 1;
	localparam det_t DMAX = (det_t'(1) <<< (DW - 1)) - det_t'(1);
	localparam det_t DMIN = -DMAX - det_t'(1);
	localparam det_t BIAS = (det_t'(1) <<< F2) - det_t'(1);
	localparam logic [DW-1:0] EMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] EMIN = {1'b1, {(DW-1){1'b0}}};

	logic adv;
	logic res_valid_q;
	res_t res_q;

	// first stage: magnitudes, signs, scaled determinant
	logic             valid_s1;
	logic [CW-1:0]    absc_s1 [NE];
	logic             negc_s1 [NE];
	logic [DETW-1:0]  absd_s1;
	logic             negd_s1;
	elem_t            dout_s1;
	logic             sing_s1;
	elem_t            e_s1 [NE];

	// division stages, index 0 is the initial remainder
	logic [DW:0]      vld_sd;
	logic [RW-1:0]    rem_sd [DW+1][NE];
	logic [DW-1:0]    nlo_sd [DW+1][NE];
	logic [DW-1:0]    quo_sd [DW+1][NE];
	logic             neg_sd [DW+1][NE];
	logic             ovf_sd [DW+1][NE];
	logic [DETW-1:0]  absd_sd [DW+1];
	elem_t            dout_sd [DW+1];
	logic             sing_sd [DW+1];
	elem_t            e_sd [DW+1][NE];

	det_t dsum, dsh;
	elem_t dout_c;
	elem_t res_e [NE];

	assign adv       = !res_valid_q || !res_stall;
	assign rd        = adv && avail;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// truncate determinant toward zero, saturate
	always_comb begin
		dsum = rdata.det + (rdata.det[DETW-1] ? BIAS : '0);
		dsh  = dsum >>> F2;
		if (dsh > DMAX) begin
			dout_c = EMAX;
		end else if (dsh < DMIN) begin
			dout_c = EMIN;
		end else begin
			dout_c = dsh[DW-1:0];
		end
	end

	// hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			vld_sd      <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= rd;
			vld_sd      <= {vld_sd[DW-1:0], valid_s1};
			res_valid_q <= vld_sd[DW];
		end
	end

	// pop request into first stage
	always_ff @(posedge clk) begin
		if (adv) begin
			absd_s1 <= rdata.det[DETW-1] ? DETW'(-rdata.det) : DETW'(rdata.det);
			negd_s1 <= rdata.det[DETW-1];
			dout_s1 <= dout_c;
			sing_s1 <= rdata.singular;
			absd_sd[0] <= absd_s1;
			dout_sd[0] <= dout_s1;
			sing_sd[0] <= sing_s1;
		end
	end

	for (genvar l = 0; l < NE; l++) begin : g_lane
		logic [NW-1:0] nfull;
		assign nfull = NW'(absc_s1[l]) << F2;

		// magnitude and sign of cofactor; overflow check and initial remainder
		always_ff @(posedge clk) begin
			if (adv) begin
				absc_s1[l]    <= rdata.c[l][CW-1] ? CW'(-rdata.c[l]) : CW'(rdata.c[l]);
				negc_s1[l]    <= rdata.c[l][CW-1];
				e_s1[l]       <= rdata.e[l];
				ovf_sd[0][l]  <= CMPW'(nfull) >= (CMPW'(absd_s1) << DW);
				rem_sd[0][l]  <= RW'(nfull >> DW);
				nlo_sd[0][l]  <= nfull[DW-1:0];
				quo_sd[0][l]  <= '0;
				neg_sd[0][l]  <= negc_s1[l] ^ negd_s1;
				e_sd[0][l]    <= e_s1[l];
			end
		end

		// one restoring step per stage
		for (genvar j = 1; j <= DW; j++) begin : g_step
			logic [RW-1:0] t;
			logic          ge;
			assign t  = {rem_sd[j-1][l][RW-2:0], nlo_sd[j-1][l][DW-1]};
			assign ge = (t >= RW'(absd_sd[j-1]));
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_sd[j][l] <= ge ? t - RW'(absd_sd[j-1]) : t;
					nlo_sd[j][l] <= nlo_sd[j-1][l] << 1;
					quo_sd[j][l] <= {quo_sd[j-1][l][DW-2:0], ge};
					neg_sd[j][l] <= neg_sd[j-1][l];
					ovf_sd[j][l] <= ovf_sd[j-1][l];
					e_sd[j][l]   <= e_sd[j-1][l];
				end
			end
		end

		// apply sign and saturate, or pass input for a singular matrix
		always_comb begin
			if (sing_sd[DW]) begin
				res_e[l] = e_sd[DW][l];
			end else if (neg_sd[DW][l]) begin
				if (ovf_sd[DW][l] || (quo_sd[DW][l] > EMIN)) begin
					res_e[l] = EMIN;
				end else begin
					res_e[l] = -quo_sd[DW][l];
				end
			end else begin
				if (ovf_sd[DW][l] || quo_sd[DW][l][DW-1]) begin
					res_e[l] = EMAX;
				end else begin
					res_e[l] = quo_sd[DW][l];
				end
			end
		end
	end

	// carry per-request fields down the divider
	for (genvar j = 1; j <= DW; j++) begin : g_carry
		always_ff @(posedge clk) begin
			if (adv) begin
				absd_sd[j] <= absd_sd[j-1];
				dout_sd[j] <= dout_sd[j-1];
				sing_sd[j] <= sing_sd[j-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_m00     <= res_e[0];
			res_q.out_m01     <= res_e[1];
			res_q.out_m02     <= res_e[2];
			res_q.out_m10     <= res_e[3];
			res_q.out_m11     <= res_e[4];
			res_q.out_m12     <= res_e[5];
			res_q.out_m20     <= res_e[6];
			res_q.out_m21     <= res_e[7];
			res_q.out_m22     <= res_e[8];
			res_q.determinant <= dout_sd[DW];
			res_q.singular    <= sing_sd[DW];
		end
	end

endmodule
